[src/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that also holds during reset.
`define CHK_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/crc16bse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 byte stream engine package
// Item types, command codes and the nibble-table CRC fold functions.
// ----------------------------------------------------------------------------
package crc16bse_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // Command kinds assigned by the front end.
    localparam logic [1:0] KIND_CONT   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_SINGLE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] crc_value;
        logic [7:0]  crc_low;
        logic [7:0]  crc_high;
        logic        frame_done;
    } t_out_item;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
    } t_cmd;

    // Reflected CRC-16 nibble table for polynomial 0xA001.
    function automatic logic [15:0] nib_table(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'h0:    val = 16'h0000;
            4'h1:    val = 16'hCC01;
            4'h2:    val = 16'hD801;
            4'h3:    val = 16'h1400;
            4'h4:    val = 16'hF001;
            4'h5:    val = 16'h3C00;
            4'h6:    val = 16'h2800;
            4'h7:    val = 16'hE401;
            4'h8:    val = 16'hA001;
            4'h9:    val = 16'h6C00;
            4'hA:    val = 16'h7800;
            4'hB:    val = 16'hB401;
            4'hC:    val = 16'h5000;
            4'hD:    val = 16'h9C01;
            4'hE:    val = 16'h8801;
            4'hF:    val = 16'h4400;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] fold_nibble(input logic [15:0] crc, input logic [3:0] nib);
        return {4'h0, crc[15:4]} ^ nib_table(crc[3:0] ^ nib);
    endfunction

    // Low nibble first, then high nibble.
    function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
        return fold_nibble(fold_nibble(crc, b[3:0]), b[7:4]);
    endfunction

endpackage

[src/crc16bse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 front end
// Registers each incoming item and classifies it by its frame flags.
// ----------------------------------------------------------------------------
module crc16bse_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  crc16bse_pkg::t_in_item  i_item,
    output logic                    o_push,
    output crc16bse_pkg::t_cmd      o_cmd,
    input  logic                    i_full
);
    import crc16bse_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // The holding register is blocked only when the queue cannot take its item.
    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    // Classify the item from its start and end flags.
    always_comb begin
        n_cmd.data_byte = i_item.data_byte;
        case ({i_item.frame_start, i_item.frame_end})
            2'b10:   n_cmd.kind = KIND_START;
            2'b01:   n_cmd.kind = KIND_END;
            2'b11:   n_cmd.kind = KIND_SINGLE;
            default: n_cmd.kind = KIND_CONT;
        endcase
    end

    // Holding register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Holding register payload.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[src/crc16bse_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 command queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module crc16bse_queue #(
    parameter int DEPTH = crc16bse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  crc16bse_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output crc16bse_pkg::t_cmd  o_cmd
);
    import crc16bse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[src/crc16bse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 back end
// Folds each queued byte into the running CRC and holds the result item.
// ----------------------------------------------------------------------------
module crc16bse_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  crc16bse_pkg::t_cmd      i_cmd,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output crc16bse_pkg::t_out_item o_item
);
    import crc16bse_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        reload;
    logic        last;

    // Take the next command whenever the output register is free or draining.
    assign o_pop   = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Decode the command kind.
    always_comb begin
        case (i_cmd.kind)
            KIND_START:  begin reload = 1'b1; last = 1'b0; end
            KIND_END:    begin reload = 1'b0; last = 1'b1; end
            KIND_SINGLE: begin reload = 1'b1; last = 1'b1; end
            default:     begin reload = 1'b0; last = 1'b0; end
        endcase
    end

    // Two nibble steps through the table.
    assign n_crc = fold_byte(reload ? CRC_INIT : r_crc, i_cmd.data_byte);

    // Running CRC and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc <= n_crc;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output item payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.crc_value  <= n_crc;
            r_out.crc_low    <= n_crc[7:0];
            r_out.crc_high   <= n_crc[15:8];
            r_out.frame_done <= last;
        end
    end

endmodule

[src/crc16_byte_stream_engine.sv]
`timescale 1ns / 1ps
// A result item passes through the front holding register, the queue and the back-end result register.
// Throughput: one byte per cycle without stalls; both nibble table steps fit in the back-end fold.
// A four-entry queue between front and back lets either side stall alone.
// Reset (synchronous, active low) empties the pipeline and loads the CRC with 0xFFFF.
// ----------------------------------------------------------------------------
// CRC-16 byte stream engine
// Reflected CRC-16 (0xA001, init 0xFFFF) over a byte stream with frame marks.
// ----------------------------------------------------------------------------
module crc16_byte_stream_engine #(
    parameter int QUEUE_DEPTH = crc16bse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  crc16bse_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output crc16bse_pkg::t_out_item o_item
);
    import crc16bse_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // Accept and classify items.
    crc16bse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    // Decoupling queue.
    crc16bse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    // CRC fold and result register.
    crc16bse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

[src/crc16bse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 port checker
// Watches the top-level ports of the CRC-16 byte stream engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc16bse_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input crc16bse_pkg::t_in_item  i_item,
    input logic                    o_valid,
    input logic                    i_stall,
    input crc16bse_pkg::t_out_item o_item
);
    import crc16bse_pkg::*;

    logic split_ok;
    logic in_accept;

    // The split bytes of the result item against its full CRC.
    assign split_ok  = (o_item.crc_low == o_item.crc_value[7:0]) &&
                       (o_item.crc_high == o_item.crc_value[15:8]);
    assign in_accept = i_valid && !o_stall;

    // A stalled result item stays offered.
    `CHK_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result item dropped while stalled")

    // The split bytes of an offered result item agree with the full CRC.
    `CHK_ASSERT(a_split, o_valid |-> split_ok, "CRC bytes disagree with CRC value")

    // After reset no result item is offered.
    `CHK_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_valid, "result item offered after reset")

    // After reset the input side is ready.
    `CHK_ASSERT_RST(a_rst_in, !i_rst_n |=> !o_stall, "input stalled after reset")

    // An idle output only wakes up once a taken input item has passed the front register,
    // the queue and the result register, since any older item would already be showing.
    `CHK_ASSERT(a_no_invent, $rose(o_valid) |-> $past(in_accept, 3), "result without input")

endmodule

bind crc16_byte_stream_engine crc16bse_checker u_chk (.*);

[bench/tb_crc16_byte_stream_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 byte stream engine testbench
// Streams framed bytes into the engine under random input gaps and output
// stalls. A shift-based CRC-16 (0xA001, reflected) predicts every result item,
// and each one is checked in order against the item that comes out.
// ----------------------------------------------------------------------------
module tb_crc16_byte_stream_engine;

    import crc16bse_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    // Expected result items, oldest first, and the predicted running CRC.
    t_out_item   crc_expect_q[$];
    logic [15:0] crc_running = CRC_INIT;

    int error_count    = 0;
    int bytes_accepted = 0;
    int results_seen   = 0;
    int frames_closed  = 0;
    int cycle_count    = 0;

    // Traffic shaping knobs set by the test tasks.
    bit tx_idle      = 1'b1;
    bit rx_random    = 1'b1;
    int hold_request = 0;

    crc16_byte_stream_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Reflected CRC-16 fold of one byte, done bit by bit. The nibble table
    // holds four of these shifts per entry, so both forms agree.
    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    // Idle gap before an item: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Predict on every accepted input item and check every accepted result.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (i_item.frame_start) crc_running = CRC_INIT;
                crc_running     = crc_fold_byte(crc_running, i_item.data_byte);
                want.crc_value  = crc_running;
                want.crc_low    = crc_running[7:0];
                want.crc_high   = crc_running[15:8];
                want.frame_done = i_item.frame_end;
                crc_expect_q.push_back(want);
                bytes_accepted++;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (crc_expect_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, o_item);
                    error_count++;
                end else begin
                    want = crc_expect_q.pop_front();
                    check_field("crc_value", want.crc_value, o_item.crc_value);
                    check_field("crc_low", {8'h00, want.crc_low}, {8'h00, o_item.crc_low});
                    check_field("crc_high", {8'h00, want.crc_high}, {8'h00, o_item.crc_high});
                    check_field("frame_done", {15'h0, want.frame_done},
                                {15'h0, o_item.frame_done});
                    if (o_item.frame_done) frames_closed++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, crc_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall runs, or a long hold-off when a test asks.
    initial begin : receiver
        int  run_left;
        int  hold_left;
        int  r;
        bit  stalled;
        run_left  = 0;
        hold_left = 0;
        stalled   = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!rx_random) begin
                i_stall <= 1'b0;
            end else begin
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        stalled  = 1'b0;
                        run_left = $urandom_range(0, 6);
                    end else if (r < 92) begin
                        stalled  = 1'b1;
                        run_left = $urandom_range(0, 2);
                    end else begin
                        stalled  = 1'b1;
                        run_left = $urandom_range(10, 30);
                    end
                end
                i_stall <= stalled;
            end
        end
    end

    // Offer one item and hold it until the engine takes it.
    task automatic send_byte(input logic [7:0] data, input logic start, input logic last);
        int       gap;
        t_in_item item;
        gap              = tx_idle ? pick_gap() : 0;
        item.data_byte   = data;
        item.frame_start = start;
        item.frame_end   = last;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_stall);
    endtask

    // One frame of random bytes; a noisy frame gets random frame marks.
    task automatic send_frame(input int len, input bit noisy);
        logic start;
        logic last;
        for (int k = 0; k < len; k++) begin
            start = (k == 0);
            last  = (k == len - 1);
            if (noisy) begin
                start = ($urandom_range(0, 3) == 0);
                last  = ($urandom_range(0, 3) == 0);
            end
            send_byte($urandom_range(0, 255), start, last);
        end
    endtask

    // Stop offering and wait for every expected result, then some slack.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (crc_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Frame mark corner cases and byte extremes.
    task automatic test_directed();
        byte unsigned check_str[9];
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        // First byte after reset with no start mark, then an end mark.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // A byte after an end without a start continues the running CRC.
        send_byte(8'hA5, 1'b0, 1'b0);
        // One-byte frames at both byte extremes.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // The usual check string, framed.
        for (int k = 0; k < 9; k++) begin
            send_byte(check_str[k], k == 0, k == 8);
        end
        // A start mark in the middle of an open frame.
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'h81, 1'b1, 1'b0);
        send_byte(8'h7E, 1'b0, 1'b1);
        drain();
    endtask

    // Output held off for a long stretch while input keeps coming.
    task automatic test_backpressure();
        tx_idle      = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 5; k++) send_frame(8, 1'b0);
        drain();
        tx_idle = 1'b1;
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_full_rate();
        int sent;
        sent      = 0;
        tx_idle   = 1'b0;
        rx_random = 1'b0;
        while (sent < 120) begin
            send_frame($urandom_range(1, 8), 1'b0);
            sent = bytes_accepted;
        end
        drain();
        tx_idle   = 1'b1;
        rx_random = 1'b1;
    endtask

    // A frame longer than 255 bytes.
    task automatic test_long_frame();
        send_frame(300, 1'b0);
        drain();
    endtask

    // Mostly well-formed frames of random length, some with broken marks.
    task automatic test_random_frames();
        int goal;
        int r;
        int len;
        goal = bytes_accepted + 450;
        while (bytes_accepted < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 8);
            else if (r < 95) len = $urandom_range(9, 40);
            else len = $urandom_range(41, 80);
            send_frame(len, $urandom_range(0, 99) < 15);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_full_rate();
        test_long_frame();
        test_random_frames();

        $display("Covered frame mark corners, a long output hold-off, full-rate bursts,");
        $display("a 300-byte frame and random frames: %0d bytes, %0d results, %0d frames.",
                 bytes_accepted, results_seen, frames_closed);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
